### src/rmf_pkg.sv
// Shared types, constants and compare functions for the RGB 3x3 median filter.
`timescale 1ns / 1ps

package rmf_pkg;

    // Default capacities handed to the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Configuration register file.
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;
    localparam int CFG_WIDTH_RST  = 640;
    localparam int CFG_HEIGHT_RST = 480;

    // One RGB pixel.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // One window column, top row first.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // Three bytes in ascending order.
    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] md;
        logic [7:0] hi;
    } chan3_t;

    // A sorted column, per channel.
    typedef struct packed {
        chan3_t r;
        chan3_t g;
        chan3_t b;
    } sorted_col_t;

    // Line memory entry: the pixel one row above and two rows above.
    typedef struct packed {
        pixel_t mid;
        pixel_t up;
    } line_entry_t;

    // Control that travels down the pipeline with each word.
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } meta_t;

    // One output word.
    typedef struct packed {
        pixel_t pix;
        logic   last;
    } result_t;

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Three compare-exchange steps sort three bytes.
    function automatic chan3_t sort3(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
        chan3_t     s;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        x = min2(a, b);
        y = max2(a, b);
        z = max2(y, c);
        y = min2(y, c);
        s.lo = min2(x, y);
        s.md = max2(x, y);
        s.hi = z;
        return s;
    endfunction

endpackage

### src/rmf_line_store.sv
// Two-row line memory with one read and one write port and same-address forwarding.
`timescale 1ns / 1ps

module rmf_line_store #(
    parameter int DEPTH = rmf_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(rmf_pkg::MAX_WIDTH_DEF)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  rmf_pkg::line_entry_t wr_data,
    output rmf_pkg::line_entry_t rd_data
);
    import rmf_pkg::*;

    line_entry_t mem [DEPTH];
    line_entry_t rdata_reg;
    line_entry_t fwd_data_reg;
    logic        fwd_reg;

    // Memory array: read returns the contents before a write in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Remember when the read collided with a write to the same entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

### src/rmf_column_cell.sv
// One column of the 3x3 window: holds three pixels, sorts them, hands them on.
`timescale 1ns / 1ps

module rmf_column_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  rmf_pkg::column_t     col_in,
    output rmf_pkg::column_t     col_out,
    output rmf_pkg::sorted_col_t sorted
);
    import rmf_pkg::*;

    column_t col_reg;

    // Column register, shifted once per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // Per-channel sort of the held column.
    always_comb
    begin
        sorted.r = sort3(col_reg.top.r, col_reg.mid.r, col_reg.bot.r);
        sorted.g = sort3(col_reg.top.g, col_reg.mid.g, col_reg.bot.g);
        sorted.b = sort3(col_reg.top.b, col_reg.mid.b, col_reg.bot.b);
    end

endmodule

### src/rmf_median.sv
// Median of nine from three sorted columns, with border pass-through.
`timescale 1ns / 1ps

module rmf_median (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  rmf_pkg::meta_t             in_meta,
    input  rmf_pkg::pixel_t            center,
    input  rmf_pkg::sorted_col_t [2:0] cols,
    output logic                       res_valid,
    output rmf_pkg::result_t           res
);
    import rmf_pkg::*;

    logic   a_valid_reg;
    meta_t  a_meta_reg;
    pixel_t a_center_reg;
    chan3_t a_r_reg;
    chan3_t a_g_reg;
    chan3_t a_b_reg;
    chan3_t r_next;
    chan3_t g_next;
    chan3_t b_next;

    // Reduce the sorted columns: largest low, median middle, smallest high.
    always_comb
    begin
        r_next.lo = max3(cols[0].r.lo, cols[1].r.lo, cols[2].r.lo);
        r_next.md = med3(cols[0].r.md, cols[1].r.md, cols[2].r.md);
        r_next.hi = min3(cols[0].r.hi, cols[1].r.hi, cols[2].r.hi);
        g_next.lo = max3(cols[0].g.lo, cols[1].g.lo, cols[2].g.lo);
        g_next.md = med3(cols[0].g.md, cols[1].g.md, cols[2].g.md);
        g_next.hi = min3(cols[0].g.hi, cols[1].g.hi, cols[2].g.hi);
        b_next.lo = max3(cols[0].b.lo, cols[1].b.lo, cols[2].b.lo);
        b_next.md = med3(cols[0].b.md, cols[1].b.md, cols[2].b.md);
        b_next.hi = min3(cols[0].b.hi, cols[1].b.hi, cols[2].b.hi);
    end

    // Reduction stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Reduction stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meta_reg   <= in_meta;
            a_center_reg <= center;
            a_r_reg      <= r_next;
            a_g_reg      <= g_next;
            a_b_reg      <= b_next;
        end
    end

    // Final median of three, or the center pixel on the border.
    always_comb
    begin
        res_valid = a_valid_reg;
        res.last  = a_meta_reg.last;
        if (a_meta_reg.border)
        begin
            res.pix = a_center_reg;
        end
        else
        begin
            res.pix.r = med3(a_r_reg.lo, a_r_reg.md, a_r_reg.hi);
            res.pix.g = med3(a_g_reg.lo, a_g_reg.md, a_g_reg.hi);
            res.pix.b = med3(a_b_reg.lo, a_b_reg.md, a_b_reg.hi);
        end
    end

endmodule

### src/rgb_median3x3_filter_top.sv
// Top level of the streaming RGB 3x3 median filter.
//
// Channel        Dir  Fields (lowest bit first)
// s_axis_*       in   tdata: red_in, green_in, blue_in; tuser: flush
// m_axis_*       out  tdata: red_out, green_out, blue_out; tlast: last_pixel
// cfg_*          in   index 0: image_width, index 1: image_height
//
// One word is accepted every clock cycle while the output buffer has room; the line
// memory is read and written once per word on its single read and single write port.
// Each result passes the line memory, window, reduction and output registers; the input
// word completing its window arrives image_width + 1 words after the pixel itself.
// Reset clears the position counters, window and pipeline valid bits; the line
// memory is not cleared and needs no clearing pass.
// A two-word output buffer holds results under backpressure; s_axis_tready drops
// in the cycle after a result arrives while the output register holds an untaken word.
`timescale 1ns / 1ps

module rgb_median3x3_filter_top #(
    parameter int MAX_WIDTH  = rmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                           s_axis_tuser,  // flush
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // red_out, green_out, blue_out
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int WM1_RST = ((CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RST) - 1;
    localparam int HM1_RST = ((CFG_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RST) - 1;

    // Configuration: stored as clamped width - 1 and height - 1.
    logic [CW-1:0]           wm1_reg;
    logic [HW-1:0]           hm1_reg;
    logic [CFG_WIDTH_W-1:0]  cfg_w_val;
    logic [CFG_HEIGHT_W-1:0] cfg_h_val;
    logic [CW-1:0]           wm1_next;
    logic [HW-1:0]           hm1_next;

    // Input stage.
    logic          adv;
    logic          accept;
    pixel_t        pix_in;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          first_col;
    logic [CW-1:0] out_col;
    logic [RW-1:0] out_row;
    logic          row_at_end;
    logic          col_at_end;
    meta_t         meta_in;

    // Line memory stage.
    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    meta_t         s1_meta_reg;
    line_entry_t   line_rd;
    line_entry_t   line_wr;
    column_t       new_col;

    // Window stage.
    logic                s2_valid_reg;
    meta_t               s2_meta_reg;
    column_t [2:0]       win_col;
    sorted_col_t [2:0]   win_sorted;

    // Result and output buffer.
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_take;

    // Clamp written values into the supported range.
    always_comb
    begin
        cfg_w_val = cfg_wdata[CFG_WIDTH_W-1:0];
        cfg_h_val = cfg_wdata[CFG_HEIGHT_W-1:0];
        if (cfg_w_val == '0)
        begin
            wm1_next = '0;
        end
        else if (32'(cfg_w_val) > 32'(MAX_WIDTH))
        begin
            wm1_next = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1_next = CW'(cfg_w_val - 1'b1);
        end
        if (cfg_h_val == '0)
        begin
            hm1_next = '0;
        end
        else if (32'(cfg_h_val) > 32'(MAX_HEIGHT))
        begin
            hm1_next = HW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1_next = HW'(cfg_h_val - 1'b1);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= CW'(WM1_RST);
            hm1_reg <= HW'(HM1_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_WIDTH:  wm1_reg <= wm1_next;
                CFG_IDX_HEIGHT: hm1_reg <= hm1_next;
                default:        ;
            endcase
        end
    end

    // The whole pipeline moves while the output buffer has room.
    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Flush words enter as black pixels.
    always_comb
    begin
        if (s_axis_tuser)
        begin
            pix_in = '0;
        end
        else
        begin
            pix_in.r = s_axis_tdata[7:0];
            pix_in.g = s_axis_tdata[15:8];
            pix_in.b = s_axis_tdata[23:16];
        end
    end

    // Position of the pixel that the current window centers on.
    always_comb
    begin
        first_col      = (col_reg == '0);
        out_col        = first_col ? wm1_reg : (col_reg - 1'b1);
        out_row        = first_col ? (row_reg - RW'(2)) : (row_reg - 1'b1);
        row_at_end     = (out_row >= RW'(hm1_reg));
        col_at_end     = (out_col >= wm1_reg);
        meta_in.emit   = (row_reg >= RW'(2)) || ((row_reg == RW'(1)) && !first_col);
        meta_in.last   = row_at_end && col_at_end;
        meta_in.border = (out_row == '0) || (out_col == '0) || row_at_end || col_at_end;
    end

    // Next input position; the end of the image restarts at the origin.
    always_comb
    begin
        if (meta_in.emit && meta_in.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_reg >= wm1_reg)
        begin
            col_next = '0;
            row_next = row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // Position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line memory stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    // Line memory stage payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pix_in;
            s1_col_reg  <= col_reg;
            s1_meta_reg <= meta_in;
        end
    end

    // Rows shift down by one inside the line memory entry.
    always_comb
    begin
        line_wr.mid = s1_pix_reg;
        line_wr.up  = line_rd.mid;
        new_col.top = line_rd.up;
        new_col.mid = line_rd.mid;
        new_col.bot = s1_pix_reg;
    end

    rmf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (col_reg),
        .wr_en   (adv && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // Window: three column cells, newest on the right.
    rmf_column_cell u_cell_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && s1_valid_reg),
        .col_in   (new_col),
        .col_out  (win_col[2]),
        .sorted   (win_sorted[2])
    );

    rmf_column_cell u_cell_center (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && s1_valid_reg),
        .col_in   (win_col[2]),
        .col_out  (win_col[1]),
        .sorted   (win_sorted[1])
    );

    rmf_column_cell u_cell_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (adv && s1_valid_reg),
        .col_in   (win_col[1]),
        .col_out  (win_col[0]),
        .sorted   (win_sorted[0])
    );

    // Window stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    rmf_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_valid_reg && s2_meta_reg.emit),
        .in_meta   (s2_meta_reg),
        .center    (win_col[1].mid),
        .cols      (win_sorted),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register with a skid word behind it.
    assign out_take = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.pix.b, out_data_reg.pix.g, out_data_reg.pix.r};
    assign m_axis_tlast  = out_data_reg.last;

endmodule

### sim/median_window_checker.sv
// Checker that predicts the filtered pixel stream of the 3x3 median filter and compares it.
`timescale 1ns / 1ps

module median_window_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                           s_axis_tuser,  // flush
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [23:0]                    m_axis_tdata,  // red_out, green_out, blue_out
    input  logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             error_count,
    output int                             results_pending
);

    localparam int LINE_DEPTH  = rmf_pkg::MAX_WIDTH_DEF;
    localparam int ROW_LIMIT   = rmf_pkg::MAX_HEIGHT_DEF;

    // Mirror of the block state: two line stores, the 3x3 window and the position.
    rmf_pkg::pixel_t                    upper_line [LINE_DEPTH];
    rmf_pkg::pixel_t                    middle_line [LINE_DEPTH];
    rmf_pkg::pixel_t                    window [9];
    logic [rmf_pkg::CFG_WIDTH_W-1:0]    width_reg;
    logic [rmf_pkg::CFG_HEIGHT_W-1:0]   height_reg;
    int unsigned                        col_pos;
    int unsigned                        row_pos;
    rmf_pkg::result_t                   expected_pixels [$];
    int                                 mismatch_count = 0;
    int                                 words_waiting = 0;
    int                                 words_checked = 0;

    assign error_count     = mismatch_count;
    assign results_pending = words_waiting;

    // A register value of zero means one; values above the capacity are clipped.
    function automatic int unsigned clip_size(input int unsigned value, input int unsigned top);
        if (value == 0)
            return 1;
        if (value > top)
            return top;
        return value;
    endfunction

    // Median of nine bytes by insertion sort.
    function automatic logic [7:0] median_of_nine(input logic [8:0][7:0] vals);
        logic [8:0][7:0] sorted;
        logic [7:0]      x;
        int              i;
        int              j;
        sorted = '0;
        for (i = 0; i < 9; i++)
        begin
            x = vals[i];
            j = i;
            while (j > 0 && sorted[j-1] > x)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = x;
        end
        return sorted[4];
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: %s", $time, what);
    endtask

    // Shift one accepted word through the line stores and window; queue the pixel it completes.
    task automatic predict_filtered_pixel(input rmf_pkg::pixel_t in_pix, input logic is_flush);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ci;
        int unsigned      ri;
        int unsigned      ro;
        int unsigned      co;
        int               i;
        rmf_pkg::pixel_t  pix;
        rmf_pkg::pixel_t  up;
        rmf_pkg::pixel_t  mid;
        logic [8:0][7:0]  reds;
        logic [8:0][7:0]  greens;
        logic [8:0][7:0]  blues;
        logic             border;
        rmf_pkg::result_t res;

        w   = clip_size(32'(width_reg), LINE_DEPTH);
        h   = clip_size(32'(height_reg), ROW_LIMIT);
        ci  = col_pos;
        ri  = row_pos;
        pix = is_flush ? '0 : in_pix;

        up  = upper_line[ci % LINE_DEPTH];
        mid = middle_line[ci % LINE_DEPTH];
        upper_line[ci % LINE_DEPTH]  = mid;
        middle_line[ci % LINE_DEPTH] = pix;

        for (i = 0; i < 3; i++)
        begin
            window[i*3]   = window[i*3+1];
            window[i*3+1] = window[i*3+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = pix;

        if (ci + 1 >= w)
        begin
            col_pos = 0;
            row_pos = ri + 1;
        end
        else
        begin
            col_pos = ci + 1;
        end

        // Nothing leaves until the window center holds a real pixel.
        if (ri >= 2 || (ri == 1 && ci >= 1))
        begin
            if (ci == 0)
            begin
                co = w - 1;
                ro = ri - 2;
            end
            else
            begin
                co = ci - 1;
                ro = ri - 1;
            end
            border   = (ro == 0) || (co == 0) || (ro >= h - 1) || (co >= w - 1);
            res.last = (ro >= h - 1) && (co >= w - 1);
            if (border)
            begin
                res.pix = window[4];
            end
            else
            begin
                for (i = 0; i < 9; i++)
                begin
                    reds[i]   = window[i].r;
                    greens[i] = window[i].g;
                    blues[i]  = window[i].b;
                end
                res.pix.r = median_of_nine(reds);
                res.pix.g = median_of_nine(greens);
                res.pix.b = median_of_nine(blues);
            end
            expected_pixels.push_back(res);
            // The final pixel restarts the position; stores and window keep their contents.
            if (res.last)
            begin
                col_pos = 0;
                row_pos = 0;
            end
        end
    endtask

    // Watch the configuration writes and both channels.
    always @(posedge clk or negedge rst_n)
    begin
        rmf_pkg::pixel_t  in_pix;
        rmf_pkg::result_t want;
        if (!rst_n)
        begin
            width_reg  = rmf_pkg::CFG_WIDTH_RST[rmf_pkg::CFG_WIDTH_W-1:0];
            height_reg = rmf_pkg::CFG_HEIGHT_RST[rmf_pkg::CFG_HEIGHT_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
            for (int k = 0; k < 9; k++)
                window[k] = '0;
            for (int k = 0; k < LINE_DEPTH; k++)
            begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            expected_pixels.delete();
            words_waiting = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rmf_pkg::CFG_IDX_WIDTH)
                    width_reg = cfg_wdata[rmf_pkg::CFG_WIDTH_W-1:0];
                else if (cfg_index == rmf_pkg::CFG_IDX_HEIGHT)
                    height_reg = cfg_wdata[rmf_pkg::CFG_HEIGHT_W-1:0];
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                in_pix.r = s_axis_tdata[7:0];
                in_pix.g = s_axis_tdata[15:8];
                in_pix.b = s_axis_tdata[23:16];
                predict_filtered_pixel(in_pix, s_axis_tuser);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("output word %0d (0x%06h) with no pixel expected",
                                              words_checked, m_axis_tdata));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== want.pix.r)
                        report_mismatch($sformatf("word %0d: red_out %0d, expected %0d",
                                                  words_checked, m_axis_tdata[7:0], want.pix.r));
                    if (m_axis_tdata[15:8] !== want.pix.g)
                        report_mismatch($sformatf("word %0d: green_out %0d, expected %0d",
                                                  words_checked, m_axis_tdata[15:8], want.pix.g));
                    if (m_axis_tdata[23:16] !== want.pix.b)
                        report_mismatch($sformatf("word %0d: blue_out %0d, expected %0d",
                                                  words_checked, m_axis_tdata[23:16], want.pix.b));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("word %0d: last_pixel %b, expected %b",
                                                  words_checked, m_axis_tlast, want.last));
                end
                words_checked++;
            end
            words_waiting = expected_pixels.size();
        end
    end

endmodule

### sim/tb_rgb_median3x3_filter_top.sv
// Testbench top: clock, reset, pixel stimulus and the verdict for the RGB 3x3 median filter.
`timescale 1ns / 1ps

module tb_rgb_median3x3_filter_top;

    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_EXTREME = 1;
    localparam int STYLE_CLUSTER = 2;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 12;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata;  // red_in, green_in, blue_in
    logic                           s_axis_tuser;  // flush
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [23:0]                    m_axis_tdata;  // red_out, green_out, blue_out
    logic                           m_axis_tlast;
    logic                           cfg_we;
    logic [rmf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rmf_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int                             error_count;
    int                             results_pending;
    int                             src_idle_pct = 22;
    int                             snk_idle_pct = 45;
    int unsigned                    eff_w;
    int unsigned                    eff_h;
    int unsigned                    pos_col;
    int unsigned                    pos_row;
    int                             items_sent;
    logic                           image_ended;
    logic [7:0]                     cluster_base;

    rgb_median3x3_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    median_window_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always #6 clk = ~clk;

    // Receiver stalls at random at the current rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("** rgb_median3x3_filter_top: FAILED **");
        $finish;
    end

    function automatic int unsigned clip_size(input int unsigned value, input int unsigned top);
        if (value == 0)
            return 1;
        if (value > top)
            return top;
        return value;
    endfunction

    function automatic logic [23:0] make_pixel(input int style);
        logic [23:0] p;
        int          i;
        p = 24'($urandom);
        for (i = 0; i < 3; i++)
        begin
            if (style == STYLE_EXTREME)
                p[i*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            else if (style == STYLE_CLUSTER)
                p[i*8 +: 8] = cluster_base + 8'($urandom_range(3));
        end
        return p;
    endfunction

    // Offer one word after a random gap and hold it until it is taken.
    task automatic send_item(input logic [23:0] data, input logic flush_bit);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= flush_bit;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        // The final pixel of an image leaves with the first word of row height + 1.
        if (pos_col == 0 && pos_row >= eff_h + 1)
        begin
            image_ended = 1'b1;
            pos_row     = 0;
        end
        else if (pos_col + 1 >= eff_w)
        begin
            pos_col = 0;
            pos_row++;
        end
        else
        begin
            pos_col++;
        end
    endtask

    // Stop sending, wait for every expected pixel, then let the pipeline settle.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_register(input logic [rmf_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[rmf_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        if (idx == rmf_pkg::CFG_IDX_WIDTH)
            eff_w = clip_size(value % 4096, rmf_pkg::MAX_WIDTH_DEF);
        else
            eff_h = clip_size(value % 8192, rmf_pkg::MAX_HEIGHT_DEF);
    endtask

    task automatic set_geometry(input int unsigned w_val, input int unsigned h_val);
        wait_for_idle();
        write_register(rmf_pkg::CFG_IDX_WIDTH, w_val);
        write_register(rmf_pkg::CFG_IDX_HEIGHT, h_val);
        cfg_we <= 1'b0;
    endtask

    // Stream one image and its flush tail; a budget of -1 runs to the final pixel.
    task automatic run_image(input int style, input int flush_pct, input int item_budget);
        int count;
        count       = 0;
        image_ended = 1'b0;
        while (!image_ended && count != item_budget)
        begin
            if (pos_row < eff_h)
                send_item(make_pixel(style), $urandom_range(99) < flush_pct);
            else
                send_item(24'($urandom), $urandom_range(99) < 90);
            count++;
        end
    endtask

    initial
    begin
        int random_start;
        int progress;
        int unsigned w;
        int unsigned h;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= rmf_pkg::CFG_IDX_WIDTH;
        cfg_wdata     <= '0;
        eff_w         = rmf_pkg::CFG_WIDTH_RST;
        eff_h         = rmf_pkg::CFG_HEIGHT_RST;
        pos_col       = 0;
        pos_row       = 0;
        items_sent    = 0;
        cluster_base  = 8'd100;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest image with an interior pixel, channels at 0 and 255, flushes inside.
        set_geometry(3, 3);
        run_image(STYLE_EXTREME, 25, -1);

        // Single-pixel image.
        set_geometry(1, 1);
        run_image(STYLE_RANDOM, 0, -1);

        // Height lowered in the middle of an image: the rest leaves as border pixels.
        set_geometry(5, 8);
        run_image(STYLE_CLUSTER, 5, 22);
        wait_for_idle();
        write_register(rmf_pkg::CFG_IDX_HEIGHT, 2);
        cfg_we <= 1'b0;
        run_image(STYLE_CLUSTER, 5, -1);

        // Width bits above the register are dropped, leaving four; zero height gives one row.
        set_geometry(4096 + 4, 0);
        run_image(STYLE_RANDOM, 2, -1);

        // Zero width gives one column.
        set_geometry(0, 6);
        run_image(STYLE_RANDOM, 2, -1);

        // Random images, mostly small; some follow back to back with the same geometry.
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            progress = items_sent - random_start;
            if (progress < RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 22;
                snk_idle_pct = 45;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct = 45;
                snk_idle_pct = 22;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if (progress == 0 || $urandom_range(99) < 60)
            begin
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 9);
                case ($urandom_range(9))
                    0: w = $urandom_range(1, 2);
                    1: h = $urandom_range(1, 2);
                    default: ;
                endcase
                set_geometry(w, h);
            end
            cluster_base = 8'($urandom_range(252));
            run_image($urandom_range(STYLE_CLUSTER), ($urandom_range(99) < 30) ? 6 : 0, -1);
        end

        wait_for_idle();
        if (error_count == 0 && results_pending == 0)
            $display("** rgb_median3x3_filter_top: PASSED **");
        else
            $display("** rgb_median3x3_filter_top: FAILED **");
        $finish;
    end

endmodule
